// ===== rtl/coo2csr_pkg.sv =====
// Package for the COO row index to CSR row pointer converter.
// Holds field widths, limits, the command word passed from the front end
// to the sequencer, and its kind codes. No dependencies.
package coo2csr_pkg;

  localparam int unsigned RowW = 6;
  localparam int unsigned PosW = 7;
  localparam int unsigned CntW = 16;

  localparam int unsigned     MaxRows    = 63;
  localparam longint unsigned MaxEntries = 65535;

  localparam logic [RowW-1:0] RowsMax   = RowW'(MaxRows);
  localparam logic [RowW-1:0] RowsReset = (MaxRows < 63) ? RowW'(MaxRows) : 6'd63;
  localparam logic [CntW-1:0] CountCap  =
      (MaxEntries < 64'd65535) ? CntW'(MaxEntries) : 16'hFFFF;

  typedef enum logic [1:0] {
    CMD_ENTRY = 2'd0,
    CMD_ERROR = 2'd1,
    CMD_EMPTY = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e       kind;
    logic [RowW-1:0] row;
    logic            last;
  } cmd_t;

endpackage

// ===== rtl/coo_row_index_to_csr_row_pointer.sv =====
// Top level of the COO row index to CSR row pointer converter.
// Holds the row count register and joins the front end and the sequencer.
// Depends on coo2csr_pkg, coo2csr_front and coo2csr_back.
//
//   Channel  Direction  Handshake            Word
//   in       input      in_valid/in_stall    row_index, last_entry, empty_set
//   out      output     out_valid/out_stall  position, pointer_value, last_output, row_error
//   cfg      input      cfg_valid/cfg_ready  num_rows
//
// The sequencer emits one pointer position per cycle while the output is not
// stalled; an entry is dequeued, emits one word per position it covers and then closes.
// An out-of-range entry emits one error word; an empty set emits num_rows plus one words.
// Reset clears the position and count and sets num_rows to its maximum.
// A two-word queue lets the input side run ahead while the output stalls.
module coo_row_index_to_csr_row_pointer import coo2csr_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [RowW-1:0] row_index_i,
  input  logic            last_entry_i,
  input  logic            empty_set_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [PosW-1:0] position_o,
  output logic [CntW-1:0] pointer_value_o,
  output logic            last_output_o,
  output logic            row_error_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [RowW-1:0] cfg_num_rows_i
);

  logic [RowW-1:0] num_rows_q, num_rows_d;
  logic            cmd_valid;
  cmd_t            cmd;
  logic            cmd_pop;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    num_rows_d = num_rows_q;
    if (cfg_valid_i) begin
      num_rows_d = (cfg_num_rows_i > RowsMax) ? RowsMax : cfg_num_rows_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_rows_q <= RowsReset;
    end else begin
      num_rows_q <= num_rows_d;
    end
  end

  coo2csr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .row_index_i  (row_index_i),
    .last_entry_i (last_entry_i),
    .empty_set_i  (empty_set_i),
    .num_rows_i   (num_rows_q),
    .cmd_valid_o  (cmd_valid),
    .cmd_o        (cmd),
    .cmd_pop_i    (cmd_pop)
  );

  coo2csr_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .num_rows_i      (num_rows_q),
    .cmd_valid_i     (cmd_valid),
    .cmd_i           (cmd),
    .cmd_pop_o       (cmd_pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .position_o      (position_o),
    .pointer_value_o (pointer_value_o),
    .last_output_o   (last_output_o),
    .row_error_o     (row_error_o)
  );

endmodule

// ===== rtl/coo2csr_front.sv =====
// Front end of the converter: accepts input words, classifies them into
// commands against the row count and queues them in a two-entry buffer.
// Depends on coo2csr_pkg.
module coo2csr_front import coo2csr_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [RowW-1:0] row_index_i,
  input  logic            last_entry_i,
  input  logic            empty_set_i,
  input  logic [RowW-1:0] num_rows_i,
  output logic            cmd_valid_o,
  output cmd_t            cmd_o,
  input  logic            cmd_pop_i
);

  cmd_t       fifo_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       full;
  logic       push;
  logic       pop;
  cmd_t       cmd_new;

  assign full = (cnt_q == 2'd2);
  assign push = in_valid_i && !full;
  assign pop  = cmd_pop_i && (cnt_q != 2'd0);

  always_comb begin
    cmd_new.row  = row_index_i;
    cmd_new.last = last_entry_i;
    if (empty_set_i) begin
      cmd_new.kind = CMD_EMPTY;
    end else if (row_index_i >= num_rows_i) begin
      cmd_new.kind = CMD_ERROR;
    end else begin
      cmd_new.kind = CMD_ENTRY;
    end
  end

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cmd_new;
    end
  end

  assign in_stall_o  = full;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = fifo_q[rd_ptr_q];

endmodule

// ===== rtl/coo2csr_back.sv =====
// Back end of the converter: a sequencer that walks the row-pointer
// positions one per cycle while the output is not stalled, and drives the registered output word.
// Depends on coo2csr_pkg.
module coo2csr_back import coo2csr_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [RowW-1:0] num_rows_i,
  input  logic            cmd_valid_i,
  input  cmd_t            cmd_i,
  output logic            cmd_pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [PosW-1:0] position_o,
  output logic [CntW-1:0] pointer_value_o,
  output logic            last_output_o,
  output logic            row_error_o
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_HEAD = 4'b0010,
    ST_TAIL = 4'b0100,
    ST_ERR  = 4'b1000
  } state_e;

  state_e          state_q, state_d;
  cmd_t            cmd_q, cmd_d;
  logic [PosW-1:0] next_pos_q, next_pos_d;
  logic [CntW-1:0] count_q, count_d;
  logic            out_valid_q, out_valid_d;
  logic [PosW-1:0] out_pos_q;
  logic [CntW-1:0] out_val_q;
  logic            out_last_q;
  logic            out_err_q;
  logic            emit_ok;
  logic            emit;
  logic [PosW-1:0] emit_pos;
  logic [CntW-1:0] emit_val;
  logic            emit_last;
  logic            emit_err;
  logic [PosW-1:0] rows_ext;
  logic [PosW-1:0] row_ext;

  assign emit_ok  = !out_valid_q || !out_stall_i;
  assign rows_ext = {1'b0, num_rows_i};
  assign row_ext  = {1'b0, cmd_q.row};

  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    next_pos_d = next_pos_q;
    count_d    = count_q;
    cmd_pop_o  = 1'b0;
    emit       = 1'b0;
    emit_pos   = next_pos_q;
    emit_val   = count_q;
    emit_last  = 1'b0;
    emit_err   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          case (cmd_i.kind)
            CMD_ENTRY: state_d = ST_HEAD;
            CMD_ERROR: state_d = ST_ERR;
            CMD_EMPTY: begin
              next_pos_d = '0;
              count_d    = '0;
              state_d    = ST_TAIL;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_HEAD: begin
        if (next_pos_q <= row_ext) begin
          if (emit_ok) begin
            emit       = 1'b1;
            next_pos_d = next_pos_q + 7'd1;
          end
        end else begin
          if (count_q < CountCap) begin
            count_d = count_q + 16'd1;
          end
          state_d = cmd_q.last ? ST_TAIL : ST_IDLE;
        end
      end
      ST_TAIL: begin
        if (next_pos_q > rows_ext) begin
          next_pos_d = '0;
          count_d    = '0;
          state_d    = ST_IDLE;
        end else if (emit_ok) begin
          emit       = 1'b1;
          emit_last  = (next_pos_q == rows_ext);
          next_pos_d = next_pos_q + 7'd1;
          if (emit_last) begin
            next_pos_d = '0;
            count_d    = '0;
            state_d    = ST_IDLE;
          end
        end
      end
      ST_ERR: begin
        if (emit_ok) begin
          emit     = 1'b1;
          emit_err = 1'b1;
          if (cmd_q.last) begin
            next_pos_d = '0;
            count_d    = '0;
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      next_pos_q  <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      next_pos_q  <= next_pos_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    if (emit) begin
      out_pos_q  <= emit_pos;
      out_val_q  <= emit_val;
      out_last_q <= emit_last;
      out_err_q  <= emit_err;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign position_o      = out_pos_q;
  assign pointer_value_o = out_val_q;
  assign last_output_o   = out_last_q;
  assign row_error_o     = out_err_q;

`ifndef SYNTHESIS
  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_pos_q <= 7'd64)
    else $error("Next position ran past the pointer array.");

  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountCap)
    else $error("Entry count exceeded its cap.");

  a_last_no_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_last_q |-> !out_err_q)
    else $error("Final position word flagged as an error.");

  a_head_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_HEAD) && emit |-> next_pos_q <= row_ext)
    else $error("Head run emitted a position beyond the entry row.");

  a_tail_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TAIL) && emit && emit_last |=> next_pos_q == '0 && count_q == '0)
    else $error("State not cleared after the final position.");
`endif

endmodule

// ===== bench/tb.sv =====
// Testbench for coo_row_index_to_csr_row_pointer: drives row index words and
// row count settings, and checks every pointer word against a predictor.
// Depends on coo2csr_pkg and the RTL of the converter.
`timescale 1ns / 1ps

module tb;
  import coo2csr_pkg::*;

  typedef struct packed {
    logic [PosW-1:0] position;
    logic [CntW-1:0] value;
    logic            last;
    logic            err;
  } ptr_word_t;

  class csr_pointer_board;
    int        rows;
    int        next_pos;
    int        count;
    ptr_word_t pointer_q[$];
    int        failures;
    int        checked;

    function new();
      rows     = int'(RowsReset);
      next_pos = 0;
      count    = 0;
      failures = 0;
      checked  = 0;
    endfunction

    function void set_rows(logic [RowW-1:0] v);
      rows = int'((v > RowsMax) ? RowsMax : v);
    endfunction

    function void push_word(int p, int v, bit l, bit e);
      ptr_word_t w;
      w.position = PosW'(p);
      w.value    = CntW'(v);
      w.last     = l;
      w.err      = e;
      pointer_q.push_back(w);
    endfunction

    function void note_entry(logic [RowW-1:0] row, logic last, logic empty);
      int r;
      r = int'(row);
      if (empty) begin
        for (int p = 0; p <= rows; p++) push_word(p, 0, p == rows, 1'b0);
        next_pos = 0;
        count    = 0;
        return;
      end
      if (r >= rows) begin
        push_word(next_pos, count, 1'b0, 1'b1);
        if (last) begin
          next_pos = 0;
          count    = 0;
        end
        return;
      end
      for (int p = next_pos; p <= r; p++) push_word(p, count, 1'b0, 1'b0);
      if (next_pos <= r) next_pos = r + 1;
      if (count < int'(CountCap)) count++;
      if (last) begin
        for (int p = next_pos; p <= rows; p++) push_word(p, count, p == rows, 1'b0);
        next_pos = 0;
        count    = 0;
      end
    endfunction

    function void check_word(logic [PosW-1:0] pos, logic [CntW-1:0] val, logic last,
                             logic err);
      ptr_word_t want;
      checked++;
      if (pointer_q.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("Unexpected word: pos %0d val %0d last %0b err %0b", pos, val, last, err);
        return;
      end
      want = pointer_q.pop_front();
      if (want.position !== pos || want.value !== val || want.last !== last ||
          want.err !== err) begin
        failures++;
        if (failures <= 10) begin
          $write("Mismatch: expected pos %0d val %0d last %0b err %0b, ",
                 want.position, want.value, want.last, want.err);
          $display("got pos %0d val %0d last %0b err %0b", pos, val, last, err);
        end
      end
    endfunction

    function int pending();
      return pointer_q.size();
    endfunction
  endclass

  logic            clk_i          = 1'b0;
  logic            rst_ni         = 1'b0;
  logic            in_valid_i     = 1'b0;
  logic            in_stall_o;
  logic [RowW-1:0] row_index_i    = '0;
  logic            last_entry_i   = 1'b0;
  logic            empty_set_i    = 1'b0;
  logic            out_valid_o;
  logic            out_stall_i    = 1'b0;
  logic [PosW-1:0] position_o;
  logic [CntW-1:0] pointer_value_o;
  logic            last_output_o;
  logic            row_error_o;
  logic            cfg_valid_i    = 1'b0;
  logic            cfg_ready_o;
  logic [RowW-1:0] cfg_num_rows_i = '0;

  csr_pointer_board board;
  bit quiet = 1'b0;
  int items_sent = 0;
  int settings_used = 0;

  coo_row_index_to_csr_row_pointer uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .row_index_i    (row_index_i),
    .last_entry_i   (last_entry_i),
    .empty_set_i    (empty_set_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .position_o     (position_o),
    .pointer_value_o(pointer_value_o),
    .last_output_o  (last_output_o),
    .row_error_o    (row_error_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_num_rows_i (cfg_num_rows_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic int gap_len();
    if ($urandom_range(0, 9) < 7) return $urandom_range(1, 3);
    return $urandom_range(8, 24);
  endfunction

  task automatic send_word(input logic [RowW-1:0] row, input logic last, input logic empty);
    int gap;
    gap = (!quiet && $urandom_range(0, 2) == 0) ? gap_len() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    row_index_i  <= row;
    last_entry_i <= last;
    empty_set_i  <= empty;
    do @(posedge clk_i); while (in_stall_o);
    board.note_entry(row, last, empty);
    items_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.pending() > 0) @(posedge clk_i);
    repeat (32) @(posedge clk_i);
  endtask

  task automatic write_rows(input logic [RowW-1:0] v);
    cfg_valid_i    <= 1'b1;
    cfg_num_rows_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    board.set_rows(v);
    settings_used++;
  endtask

  task automatic send_matrix(input int nr);
    int len;
    int cur;
    int r;
    len = $urandom_range(1, 6);
    cur = 0;
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 19);
      if (r == 0) begin
        send_word(RowW'($urandom_range(nr, 63)), i == len - 1, 1'b0);
      end else if (r == 1 && cur > 0) begin
        send_word(RowW'($urandom_range(0, cur - 1)), 1'b0, 1'b0);
      end else begin
        cur = cur + $urandom_range(0, nr / len + 1);
        if (cur >= nr) cur = nr - 1;
        send_word(RowW'(cur), i == len - 1 && r != 2, 1'b0);
      end
    end
  endtask

  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i)
        board.check_word(position_o, pointer_value_o, last_output_o, row_error_o);
      if (stall_left > 0) begin
        stall_left--;
        if (stall_left == 0) out_stall_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        stall_left = gap_len();
        out_stall_i <= 1'b1;
      end
    end
  end

  initial begin
    #(100_000_000);
    $display("Timeout with %0d words still expected.", board.pending());
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int nr;
    int k;
    int waited;
    board = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_word(6'd0, 1'b0, 1'b1);
    send_word(6'd0, 1'b0, 1'b0);
    send_word(6'd0, 1'b0, 1'b0);
    send_word(6'd5, 1'b0, 1'b0);
    send_word(6'd3, 1'b0, 1'b0);
    send_word(6'd62, 1'b1, 1'b0);
    send_word(6'd10, 1'b0, 1'b0);
    send_word(6'd63, 1'b0, 1'b0);
    send_word(6'd63, 1'b1, 1'b0);
    send_word(6'd0, 1'b1, 1'b0);
    send_word(6'd3, 1'b0, 1'b0);
    send_word(6'd17, 1'b1, 1'b1);
    send_word(6'd40, 1'b0, 1'b0);
    drain();
    write_rows(6'd10);
    send_word(6'd5, 1'b1, 1'b0);
    drain();
    write_rows(6'd0);
    send_word(6'd0, 1'b0, 1'b1);
    send_word(6'd0, 1'b0, 1'b0);
    send_word(6'd63, 1'b1, 1'b0);
    send_word(6'd63, 1'b1, 1'b1);
    drain();
    write_rows(6'd1);
    send_word(6'd0, 1'b1, 1'b0);
    send_word(6'd0, 1'b0, 1'b1);
    send_word(6'd1, 1'b1, 1'b0);
    drain();

    while (items_sent < 300) begin
      k = $urandom_range(0, 9);
      if (k == 0) nr = 0;
      else if (k == 1) nr = 63;
      else if (k == 2) nr = 1;
      else nr = $urandom_range(2, 62);
      quiet = ($urandom_range(0, 4) == 0);
      write_rows(RowW'(nr));
      repeat ($urandom_range(3, 8)) begin
        k = $urandom_range(0, 99);
        if (k < 8)
          send_word(RowW'($urandom_range(0, 63)), 1'($urandom_range(0, 1)), 1'b1);
        else if (k < 20 || nr == 0)
          send_word(RowW'($urandom_range(0, 63)), 1'($urandom_range(0, 1)), 1'b0);
        else
          send_matrix(nr);
      end
      drain();
    end
    quiet = 1'b0;

    in_valid_i <= 1'b0;
    waited = 0;
    while (board.pending() > 0 && waited < 100000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (32) @(posedge clk_i);

    $display("Sent %0d row index words over %0d row counts; checked %0d words.",
             items_sent, settings_used, board.checked);
    $display("Covered empty sets, repeated and out-of-order rows and range errors.");
    if (board.failures == 0 && board.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches, %0d words never arrived.", board.failures, board.pending());
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
